// File: rtl/dsdt_pkg.sv
// dsdt_pkg: shared widths, codes and control structs of the dust sensor delta tracker
// used by dsdt_div, dsdt_ctrl, dsdt_dp and dust_sensor_delta_tracker
// depends on nothing
package dsdt_pkg;

	// window geometry
	localparam int WINDOW_DEPTH = 10;
	localparam int HEAD_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

	// field widths
	localparam int LVL_W   = 20;
	localparam int DELTA_W = 21;
	localparam int SUM_W   = LVL_W + FILL_W;
	localparam int BASE_W  = 30;
	localparam int SM_W    = 28;
	localparam int S_W     = 36;

	// shared divider, two quotient bits per cycle
	localparam int DIV_NW    = 44;
	localparam int DIV_DW    = 30;
	localparam int DIV_STEPS = DIV_NW / 2;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// fixed-point constants, 16 fraction bits
	localparam int ADAPT_Q16 = 328;
	localparam int FLOOR_Q16 = 1311;
	localparam int ROUND_Q16 = 32768;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_WARMUP    = 3'd0,
		CFG_CALIB     = 3'd1,
		CFG_MIN_ON    = 3'd2,
		CFG_MIN_DELTA = 3'd3,
		CFG_MAX_RISE  = 3'd4,
		CFG_DECAY     = 3'd5,
		CFG_FS_LEVEL  = 3'd6,
		CFG_FS_PM     = 3'd7
	} cfg_idx_t;

	// reported status codes
	typedef enum logic [1:0] {
		ST_NO_SIGNAL = 2'd0,
		ST_WARMUP    = 2'd1,
		ST_CALIB     = 2'd2,
		ST_READY     = 2'd3
	} status_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE       = 5'd0,
		OP_LOAD       = 5'd1,
		OP_DIV_OFF    = 5'd2,
		OP_DIV_ON     = 5'd3,
		OP_RAW        = 5'd4,
		OP_CAL_MUL    = 5'd5,
		OP_DIV_CAL    = 5'd6,
		OP_ADAPT_MUL  = 5'd7,
		OP_ADAPT_SUB  = 5'd8,
		OP_TARGET     = 5'd9,
		OP_SMOOTH_MUL = 5'd10,
		OP_SMOOTH_UPD = 5'd11,
		OP_PM_CHECK   = 5'd12,
		OP_DIV_PCT    = 5'd13,
		OP_DIV_PM     = 5'd14,
		OP_STATUS     = 5'd15,
		OP_OUT        = 5'd16
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic cal_div;
		logic pm_skip;
	} sts_t;

endpackage

// File: rtl/dsdt_div.sv
// dsdt_div: unsigned restoring divider, two quotient bits per cycle
// depends on dsdt_pkg
module dsdt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dsdt_pkg::DIV_NW-1:0]  num,
	input  logic [dsdt_pkg::DIV_DW-1:0]  den,
	output logic                         done,
	output logic [dsdt_pkg::DIV_NW-1:0]  quo
);

	logic [dsdt_pkg::DIV_NW-1:0] num_q;
	logic [dsdt_pkg::DIV_DW-1:0] den_q;
	logic [dsdt_pkg::DIV_DW-1:0] rem_q;
	logic [dsdt_pkg::DIV_CW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [dsdt_pkg::DIV_DW:0]   t1, t2;
	logic                        g1, g2;
	logic [dsdt_pkg::DIV_DW-1:0] r1, r2;

	// two restoring steps
	always_comb begin
		t1 = {rem_q, num_q[dsdt_pkg::DIV_NW-1]};
		g1 = (t1 >= {1'b0, den_q});
		r1 = g1 ? dsdt_pkg::DIV_DW'(t1 - {1'b0, den_q}) : t1[dsdt_pkg::DIV_DW-1:0];
		t2 = {r1, num_q[dsdt_pkg::DIV_NW-2]};
		g2 = (t2 >= {1'b0, den_q});
		r2 = g2 ? dsdt_pkg::DIV_DW'(t2 - {1'b0, den_q}) : t2[dsdt_pkg::DIV_DW-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dsdt_pkg::DIV_CW'(dsdt_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// numerator shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[dsdt_pkg::DIV_NW-3:0], g1, g2};
			rem_q <= r2;
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

// File: rtl/dsdt_ctrl.sv
// dsdt_ctrl: sequencer for one measurement and the output handshake
// depends on dsdt_pkg
module dsdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dsdt_pkg::sts_t  sts,
	output dsdt_pkg::cmd_t  cmd
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_DOFF  = 21'h000002,
		S_WOFF  = 21'h000004,
		S_DON   = 21'h000008,
		S_WON   = 21'h000010,
		S_RAW   = 21'h000020,
		S_CMUL  = 21'h000040,
		S_DCAL  = 21'h000080,
		S_WCAL  = 21'h000100,
		S_AMUL  = 21'h000200,
		S_ASUB  = 21'h000400,
		S_TGT   = 21'h000800,
		S_SMUL  = 21'h001000,
		S_SUPD  = 21'h002000,
		S_PMCHK = 21'h004000,
		S_DPCT  = 21'h008000,
		S_WPCT  = 21'h010000,
		S_DPM   = 21'h020000,
		S_WPM   = 21'h040000,
		S_STAT  = 21'h080000,
		S_DONE  = 21'h100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = dsdt_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = dsdt_pkg::OP_LOAD;
					state_d = S_DOFF;
				end
			end
			S_DOFF: begin
				cmd.op  = dsdt_pkg::OP_DIV_OFF;
				state_d = S_WOFF;
			end
			S_WOFF: if (sts.div_done) state_d = S_DON;
			S_DON: begin
				cmd.op  = dsdt_pkg::OP_DIV_ON;
				state_d = S_WON;
			end
			S_WON: if (sts.div_done) state_d = S_RAW;
			S_RAW: begin
				cmd.op  = dsdt_pkg::OP_RAW;
				state_d = sts.cal_div ? S_CMUL : S_AMUL;
			end
			S_CMUL: begin
				cmd.op  = dsdt_pkg::OP_CAL_MUL;
				state_d = S_DCAL;
			end
			S_DCAL: begin
				cmd.op  = dsdt_pkg::OP_DIV_CAL;
				state_d = S_WCAL;
			end
			S_WCAL: if (sts.div_done) state_d = S_AMUL;
			S_AMUL: begin
				cmd.op  = dsdt_pkg::OP_ADAPT_MUL;
				state_d = S_ASUB;
			end
			S_ASUB: begin
				cmd.op  = dsdt_pkg::OP_ADAPT_SUB;
				state_d = S_TGT;
			end
			S_TGT: begin
				cmd.op  = dsdt_pkg::OP_TARGET;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				cmd.op  = dsdt_pkg::OP_SMOOTH_MUL;
				state_d = S_SUPD;
			end
			S_SUPD: begin
				cmd.op  = dsdt_pkg::OP_SMOOTH_UPD;
				state_d = S_PMCHK;
			end
			S_PMCHK: begin
				cmd.op  = dsdt_pkg::OP_PM_CHECK;
				state_d = sts.pm_skip ? S_STAT : S_DPCT;
			end
			S_DPCT: begin
				cmd.op  = dsdt_pkg::OP_DIV_PCT;
				state_d = S_WPCT;
			end
			S_WPCT: if (sts.div_done) state_d = S_DPM;
			S_DPM: begin
				cmd.op  = dsdt_pkg::OP_DIV_PM;
				state_d = S_WPM;
			end
			S_WPM: if (sts.div_done) state_d = S_STAT;
			S_STAT: begin
				cmd.op  = dsdt_pkg::OP_STATUS;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = dsdt_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == dsdt_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready)             out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// divider finishes only while a wait state listens
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_WOFF || state_q == S_WON || state_q == S_WCAL ||
			state_q == S_WPCT || state_q == S_WPM))
		else $error("divider done outside a wait state");

	// a new result appears only from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result shown without completing a measurement");

	// an accepted transaction starts the window division
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DOFF))
		else $error("accepted transaction did not start processing");

endmodule

// File: rtl/dsdt_dp.sv
// dsdt_dp: window, baseline, smoothing and scaling datapath with configuration registers
// depends on dsdt_pkg and dsdt_div
module dsdt_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dsdt_pkg::cmd_t                     cmd,
	output dsdt_pkg::sts_t                     sts,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [dsdt_pkg::LVL_W-1:0]         cfg_data,
	input  logic [dsdt_pkg::LVL_W-1:0]         off_level,
	input  logic [dsdt_pkg::LVL_W-1:0]         on_level,
	output logic [dsdt_pkg::LVL_W-1:0]         off_avg,
	output logic [dsdt_pkg::LVL_W-1:0]         on_avg,
	output logic signed [dsdt_pkg::DELTA_W-1:0] raw_delta,
	output logic signed [dsdt_pkg::DELTA_W-1:0] baseline_out,
	output logic [dsdt_pkg::LVL_W-1:0]         smoothed_out,
	output logic [6:0]                         level_pct,
	output logic [2:0]                         level_class,
	output logic [13:0]                        pm_tenths,
	output logic [1:0]                         status,
	output logic                               ready_res
);

	typedef enum logic [2:0] {
		DST_OFF = 3'd0,
		DST_ON  = 3'd1,
		DST_CAL = 3'd2,
		DST_PCT = 3'd3,
		DST_PM  = 3'd4
	} dest_t;

	// configuration
	logic [3:0]  warm_q, cal_cnt_q;
	logic [19:0] min_on_q, min_delta_q, fsl_q;
	logic [15:0] max_rise_q, decay_q;
	logic [9:0]  fspm_q;

	// window and measurement state
	logic [dsdt_pkg::LVL_W-1:0]  off_win_q [dsdt_pkg::WINDOW_DEPTH];
	logic [dsdt_pkg::LVL_W-1:0]  on_win_q  [dsdt_pkg::WINDOW_DEPTH];
	logic [dsdt_pkg::HEAD_W-1:0] head_q;
	logic [dsdt_pkg::FILL_W-1:0] fill_q;
	logic [dsdt_pkg::SUM_W-1:0]  sum_off_q, sum_on_q;
	logic [3:0]                  calib_done_q;
	logic [7:0]                  streak_q;
	logic signed [dsdt_pkg::BASE_W-1:0] base_q;
	logic [dsdt_pkg::SM_W-1:0]   sm_q;

	// per-item working registers
	logic [dsdt_pkg::LVL_W-1:0]  off_avg_q, on_avg_q;
	logic signed [dsdt_pkg::DELTA_W-1:0] raw_q;
	logic                        valid_q;
	logic signed [dsdt_pkg::S_W-1:0] s_q;
	logic                        cal_neg_q;
	logic                        adapt_en_q;
	logic                        rise_q;
	logic [dsdt_pkg::SM_W-1:0]   target_q;
	logic [dsdt_pkg::DIV_NW-1:0] mul_q;
	logic [6:0]                  pct_q;
	logic [13:0]                 pm_q;
	logic [1:0]                  status_q;
	dest_t                       dest_q;

	// output registers
	logic [dsdt_pkg::LVL_W-1:0]  off_out_q, on_out_q, sm_out_q;
	logic signed [dsdt_pkg::DELTA_W-1:0] raw_out_q, base_out_q;
	logic [6:0]                  pct_out_q;
	logic [2:0]                  cls_out_q;
	logic [13:0]                 pm_out_q;
	logic [1:0]                  status_out_q;

	// divider hookup
	logic                        div_start, div_done;
	logic [dsdt_pkg::DIV_NW-1:0] div_num, div_quo;
	logic [dsdt_pkg::DIV_DW-1:0] div_den;

	// combinational helpers
	logic [dsdt_pkg::LVL_W-1:0]  old_off, old_on;
	logic signed [dsdt_pkg::DELTA_W-1:0] raw_c;
	logic [dsdt_pkg::DELTA_W-1:0] absd_c;
	logic signed [dsdt_pkg::BASE_W-1:0] raw16_c, raw16_q;
	logic                        cal_en;
	logic [4:0]                  n_plus1;
	logic signed [dsdt_pkg::S_W:0] a_c;
	logic [dsdt_pkg::S_W:0]      a_mag;
	logic signed [dsdt_pkg::BASE_W:0] diff_c;
	logic [dsdt_pkg::SM_W-1:0]   target_c;
	logic [dsdt_pkg::SM_W-1:0]   rise_c;
	logic [23:0]                 cap_c;
	logic [dsdt_pkg::SM_W:0]     sm_next;
	logic [dsdt_pkg::DIV_NW:0]   decay_sum;
	logic [27:0]                 den_c;
	logic [14:0]                 fspm20;
	logic [dsdt_pkg::SM_W-1:0]   adapt_step;
	logic [7:0]                  streak_inc;
	logic [2:0]                  cls_c;

	assign old_off  = off_win_q[head_q];
	assign old_on   = on_win_q[head_q];
	assign raw_c    = dsdt_pkg::DELTA_W'(signed'({1'b0, on_avg_q})) -
		dsdt_pkg::DELTA_W'(signed'({1'b0, off_avg_q}));
	assign absd_c   = raw_c[dsdt_pkg::DELTA_W-1] ? dsdt_pkg::DELTA_W'(-raw_c) : raw_c;
	assign raw16_c  = {raw_c[dsdt_pkg::DELTA_W-1], raw_c, 8'd0};
	assign raw16_q  = {raw_q[dsdt_pkg::DELTA_W-1], raw_q, 8'd0};
	assign cal_en   = (streak_q >= {4'd0, warm_q}) && (calib_done_q < cal_cnt_q);
	assign n_plus1  = {1'b0, calib_done_q} + 5'd1;
	assign den_c    = {fsl_q, 8'd0};
	assign fspm20   = 15'({fspm_q, 4'd0}) + 15'({fspm_q, 2'd0});
	assign cap_c    = {max_rise_q, 8'd0};

	// calibration numerator 2s + n + 1, negatives use the ceiling form
	always_comb begin
		a_c   = (dsdt_pkg::S_W+1)'(s_q) * 2 + (dsdt_pkg::S_W+1)'(signed'({1'b0, n_plus1}));
		a_mag = a_c[dsdt_pkg::S_W] ? (dsdt_pkg::S_W+1)'(-a_c + ((n_plus1 * 2) - 1)) : a_c;
	end

	// target clamp
	always_comb begin
		diff_c = (dsdt_pkg::BASE_W+1)'(raw16_q) - (dsdt_pkg::BASE_W+1)'(base_q);
		if (diff_c < 0)
			target_c = '0;
		else if (diff_c > (dsdt_pkg::BASE_W+1)'((1 << dsdt_pkg::SM_W) - 1))
			target_c = '1;
		else
			target_c = diff_c[dsdt_pkg::SM_W-1:0];
	end

	// smoothing update
	always_comb begin
		rise_c    = target_q - sm_q;
		decay_sum = {1'b0, mul_q} + (dsdt_pkg::DIV_NW+1)'(dsdt_pkg::ROUND_Q16);
		if (rise_q)
			sm_next = {1'b0, sm_q} + ((rise_c > 28'(cap_c)) ? 29'(cap_c) : 29'(rise_c));
		else
			sm_next = {1'b0, target_q} + 29'(decay_sum >> 16);
	end

	assign adapt_step = 28'(({4'd0, mul_q[39:0]} + 44'(dsdt_pkg::ROUND_Q16)) >> 16);
	assign streak_inc = (streak_q == 8'hFF) ? streak_q : streak_q + 8'd1;

	// level class from percentage
	always_comb begin
		if (pct_q < 7'd10)      cls_c = 3'd0;
		else if (pct_q < 7'd35) cls_c = 3'd1;
		else if (pct_q < 7'd65) cls_c = 3'd2;
		else if (pct_q < 7'd90) cls_c = 3'd3;
		else                    cls_c = 3'd4;
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			dsdt_pkg::OP_DIV_OFF: begin
				div_start = 1'b1;
				div_num   = dsdt_pkg::DIV_NW'(sum_off_q + dsdt_pkg::SUM_W'(fill_q >> 1));
				div_den   = dsdt_pkg::DIV_DW'(fill_q);
			end
			dsdt_pkg::OP_DIV_ON: begin
				div_start = 1'b1;
				div_num   = dsdt_pkg::DIV_NW'(sum_on_q + dsdt_pkg::SUM_W'(fill_q >> 1));
				div_den   = dsdt_pkg::DIV_DW'(fill_q);
			end
			dsdt_pkg::OP_DIV_CAL: begin
				div_start = 1'b1;
				div_num   = dsdt_pkg::DIV_NW'(a_mag);
				div_den   = dsdt_pkg::DIV_DW'({n_plus1, 1'b0});
			end
			dsdt_pkg::OP_DIV_PCT: begin
				div_start = 1'b1;
				div_num   = dsdt_pkg::DIV_NW'(36'(sm_q) * 36'd200 + 36'(den_c));
				div_den   = dsdt_pkg::DIV_DW'({den_c, 1'b0});
			end
			dsdt_pkg::OP_DIV_PM: begin
				div_start = 1'b1;
				div_num   = mul_q + dsdt_pkg::DIV_NW'(den_c);
				div_den   = dsdt_pkg::DIV_DW'({den_c, 1'b0});
			end
			default: ;
		endcase
	end

	dsdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q      <= 4'd3;
			cal_cnt_q   <= 4'd8;
			min_on_q    <= 20'd512;
			min_delta_q <= 20'd256;
			max_rise_q  <= 16'd77;
			decay_q     <= 16'd58982;
			fsl_q       <= 20'd2048;
			fspm_q      <= 10'd500;
		end else if (cfg_we) begin
			case (dsdt_pkg::cfg_idx_t'(cfg_index))
				dsdt_pkg::CFG_WARMUP:    warm_q      <= cfg_data[3:0];
				dsdt_pkg::CFG_CALIB:     cal_cnt_q   <= cfg_data[3:0];
				dsdt_pkg::CFG_MIN_ON:    min_on_q    <= cfg_data;
				dsdt_pkg::CFG_MIN_DELTA: min_delta_q <= cfg_data;
				dsdt_pkg::CFG_MAX_RISE:  max_rise_q  <= cfg_data[15:0];
				dsdt_pkg::CFG_DECAY:     decay_q     <= cfg_data[15:0];
				dsdt_pkg::CFG_FS_LEVEL:  fsl_q       <= cfg_data;
				dsdt_pkg::CFG_FS_PM:     fspm_q      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// window entries, written at the head only
	always_ff @(posedge clk) begin
		if (cmd.op == dsdt_pkg::OP_LOAD) begin
			off_win_q[head_q] <= off_level;
			on_win_q[head_q]  <= on_level;
		end
	end

	// tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			fill_q       <= '0;
			sum_off_q    <= '0;
			sum_on_q     <= '0;
			calib_done_q <= '0;
			streak_q     <= '0;
			base_q       <= '0;
			sm_q         <= '0;
		end else begin
			case (cmd.op)
				dsdt_pkg::OP_LOAD: begin
					head_q <= (head_q == dsdt_pkg::HEAD_W'(dsdt_pkg::WINDOW_DEPTH - 1)) ?
						'0 : head_q + 1'b1;
					if (fill_q == dsdt_pkg::FILL_W'(dsdt_pkg::WINDOW_DEPTH)) begin
						sum_off_q <= sum_off_q + dsdt_pkg::SUM_W'(off_level) -
							dsdt_pkg::SUM_W'(old_off);
						sum_on_q  <= sum_on_q + dsdt_pkg::SUM_W'(on_level) -
							dsdt_pkg::SUM_W'(old_on);
					end else begin
						fill_q    <= fill_q + 1'b1;
						sum_off_q <= sum_off_q + dsdt_pkg::SUM_W'(off_level);
						sum_on_q  <= sum_on_q + dsdt_pkg::SUM_W'(on_level);
					end
				end
				dsdt_pkg::OP_RAW: begin
					// first calibration delta is taken as the baseline
					if (cal_en && calib_done_q == '0) begin
						base_q       <= raw16_c;
						calib_done_q <= calib_done_q + 4'd1;
					end
				end
				dsdt_pkg::OP_ADAPT_SUB: begin
					if (adapt_en_q) base_q <= base_q - dsdt_pkg::BASE_W'(adapt_step);
				end
				dsdt_pkg::OP_SMOOTH_UPD: begin
					sm_q <= (sm_next < 29'(dsdt_pkg::FLOOR_Q16)) ? '0 : sm_next[dsdt_pkg::SM_W-1:0];
				end
				dsdt_pkg::OP_STATUS: begin
					streak_q <= valid_q ? streak_inc : 8'd0;
				end
				default: ;
			endcase
			// running calibration mean lands from the divider
			if (div_done && dest_q == DST_CAL) begin
				base_q <= cal_neg_q ? -dsdt_pkg::BASE_W'(div_quo) : dsdt_pkg::BASE_W'(div_quo);
				calib_done_q <= calib_done_q + 4'd1;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			dsdt_pkg::OP_DIV_OFF: dest_q <= DST_OFF;
			dsdt_pkg::OP_DIV_ON:  dest_q <= DST_ON;
			dsdt_pkg::OP_DIV_PCT: dest_q <= DST_PCT;
			dsdt_pkg::OP_DIV_PM:  dest_q <= DST_PM;
			dsdt_pkg::OP_DIV_CAL: begin
				dest_q    <= DST_CAL;
				cal_neg_q <= a_c[dsdt_pkg::S_W];
			end
			dsdt_pkg::OP_RAW: begin
				raw_q   <= raw_c;
				valid_q <= (on_avg_q >= min_on_q) || (absd_c >= {1'b0, min_delta_q});
			end
			dsdt_pkg::OP_CAL_MUL: begin
				s_q <= dsdt_pkg::S_W'(base_q) *
					dsdt_pkg::S_W'(signed'({1'b0, calib_done_q})) +
					dsdt_pkg::S_W'(raw16_q);
			end
			dsdt_pkg::OP_ADAPT_MUL: begin
				adapt_en_q <= (calib_done_q >= cal_cnt_q) && (raw16_q <= base_q);
				mul_q      <= dsdt_pkg::DIV_NW'(base_q - raw16_q) *
					dsdt_pkg::DIV_NW'(dsdt_pkg::ADAPT_Q16);
			end
			dsdt_pkg::OP_TARGET: target_q <= target_c;
			dsdt_pkg::OP_SMOOTH_MUL: begin
				rise_q <= target_q > sm_q;
				mul_q  <= dsdt_pkg::DIV_NW'(sm_q - target_q) * dsdt_pkg::DIV_NW'(decay_q);
			end
			dsdt_pkg::OP_PM_CHECK: begin
				mul_q <= dsdt_pkg::DIV_NW'(sm_q) * dsdt_pkg::DIV_NW'(fspm20);
				if (fsl_q == '0) begin
					pct_q <= 7'd0;
					pm_q  <= 14'd0;
				end else begin
					pct_q <= 7'd100;
					pm_q  <= 14'(fspm_q) * 14'd10;
				end
			end
			dsdt_pkg::OP_STATUS: begin
				if (!valid_q)                  status_q <= dsdt_pkg::ST_NO_SIGNAL;
				else if (streak_inc < {4'd0, warm_q}) status_q <= dsdt_pkg::ST_WARMUP;
				else if (calib_done_q < cal_cnt_q)    status_q <= dsdt_pkg::ST_CALIB;
				else                           status_q <= dsdt_pkg::ST_READY;
			end
			default: ;
		endcase
		if (div_done) begin
			case (dest_q)
				DST_OFF: off_avg_q <= div_quo[dsdt_pkg::LVL_W-1:0];
				DST_ON:  on_avg_q  <= div_quo[dsdt_pkg::LVL_W-1:0];
				DST_PCT: pct_q     <= div_quo[6:0];
				DST_PM:  pm_q      <= div_quo[13:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.op == dsdt_pkg::OP_OUT) begin
			off_out_q    <= off_avg_q;
			on_out_q     <= on_avg_q;
			raw_out_q    <= raw_q;
			base_out_q   <= base_q[dsdt_pkg::DELTA_W+7:8];
			sm_out_q     <= sm_q[dsdt_pkg::SM_W-1:8];
			pct_out_q    <= pct_q;
			cls_out_q    <= cls_c;
			pm_out_q     <= pm_q;
			status_out_q <= status_q;
		end
	end

	// status to controller
	assign sts.div_done = div_done;
	assign sts.cal_div  = cal_en && (calib_done_q != '0);
	assign sts.pm_skip  = (fsl_q == '0) || (sm_q >= den_c);

	assign off_avg      = off_out_q;
	assign on_avg       = on_out_q;
	assign raw_delta    = raw_out_q;
	assign baseline_out = base_out_q;
	assign smoothed_out = sm_out_q;
	assign level_pct    = pct_out_q;
	assign level_class  = cls_out_q;
	assign pm_tenths    = pm_out_q;
	assign status       = status_out_q;
	assign ready_res    = (status_out_q == dsdt_pkg::ST_READY);

endmodule

// File: rtl/dust_sensor_delta_tracker.sv
// dust_sensor_delta_tracker: top level, joins sequencer and datapath
// depends on dsdt_pkg, dsdt_ctrl, dsdt_dp
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready    off_level, on_level
// out       output     out_valid / out_ready  off_avg .. ready_res
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// each measurement runs up to five divisions in turn on the shared two-bit-per-cycle divider:
// the two window averages, a calibration division for each calibration step after the first,
// and the percentage and PM2.5 divisions, both skipped at zero or reached full scale
// asynchronous active-low reset restores register defaults and clears all tracking state
// a finished result waits in the output register while the next transaction is taken
// a stalled output holds the sequencer in its last state until the result is taken
module dust_sensor_delta_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dsdt_pkg::LVL_W-1:0]           off_level,
	input  logic [dsdt_pkg::LVL_W-1:0]           on_level,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dsdt_pkg::LVL_W-1:0]           off_avg,
	output logic [dsdt_pkg::LVL_W-1:0]           on_avg,
	output logic signed [dsdt_pkg::DELTA_W-1:0]  raw_delta,
	output logic signed [dsdt_pkg::DELTA_W-1:0]  baseline_out,
	output logic [dsdt_pkg::LVL_W-1:0]           smoothed_out,
	output logic [6:0]                           level_pct,
	output logic [2:0]                           level_class,
	output logic [13:0]                          pm_tenths,
	output logic [1:0]                           status,
	output logic                                 ready_res,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_index,
	input  logic [dsdt_pkg::LVL_W-1:0]           cfg_data
);

	dsdt_pkg::cmd_t cmd;
	dsdt_pkg::sts_t sts;

	// sequencer
	dsdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	dsdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.off_level    (off_level),
		.on_level     (on_level),
		.off_avg      (off_avg),
		.on_avg       (on_avg),
		.raw_delta    (raw_delta),
		.baseline_out (baseline_out),
		.smoothed_out (smoothed_out),
		.level_pct    (level_pct),
		.level_class  (level_class),
		.pm_tenths    (pm_tenths),
		.status       (status),
		.ready_res    (ready_res)
	);

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for dust_sensor_delta_tracker
// depends on dsdt_pkg and the dust_sensor_delta_tracker rtl
// a behavioral predictor computes each result; a monitor compares transactions in order
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 1500000;

	// expected result of one measurement
	typedef struct {
		logic [19:0] off_avg;
		logic [19:0] on_avg;
		logic [20:0] raw_delta;
		logic [20:0] baseline;
		logic [19:0] smoothed;
		logic [6:0]  pct;
		logic [2:0]  cls;
		logic [13:0] pm;
		logic [1:0]  status;
		logic        rdy;
	} tracker_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [19:0] off_level = '0;
	logic [19:0] on_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [19:0] off_avg, on_avg, smoothed_out;
	logic signed [20:0] raw_delta, baseline_out;
	logic [6:0] level_pct;
	logic [2:0] level_class;
	logic [13:0] pm_tenths;
	logic [1:0] status;
	logic ready_res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	dust_sensor_delta_tracker uut (.*);

	// predictor state and register copy
	logic [19:0] off_win [dsdt_pkg::WINDOW_DEPTH];
	logic [19:0] on_win [dsdt_pkg::WINDOW_DEPTH];
	int unsigned win_head, win_fill, calib_n, streak;
	longint baseline_q16, smooth_q16;
	int unsigned r_warm, r_calib, r_min_on, r_min_delta, r_rise, r_decay, r_fs, r_fs_pm;

	tracker_res_t expected_q[$];
	int errors = 0;
	bit rx_hold = 1'b0;
	bit idle_on = 1'b1;
	longint cycles = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic longint fdiv(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q--;
		return q;
	endfunction

	// registers back to their reset values
	task automatic defaults_reset();
		win_head = 0; win_fill = 0; calib_n = 0; streak = 0;
		baseline_q16 = 0; smooth_q16 = 0;
		r_warm = 3; r_calib = 8; r_min_on = 512; r_min_delta = 256;
		r_rise = 77; r_decay = 58982; r_fs = 2048; r_fs_pm = 500;
	endtask

	// one measurement through the tracker algorithm
	function automatic tracker_res_t track_measurement(logic [19:0] offv, logic [19:0] onv);
		tracker_res_t r;
		longint s_off, s_on, oa, na, raw, raw16, target, absd, rise, den, acc;
		longint unsigned d;
		int unsigned pct, pm, cls, st;
		bit ok;
		off_win[win_head] = offv;
		on_win[win_head] = onv;
		win_head = (win_head + 1) % dsdt_pkg::WINDOW_DEPTH;
		if (win_fill < dsdt_pkg::WINDOW_DEPTH) win_fill++;
		s_off = 0; s_on = 0;
		for (int i = 0; i < win_fill; i++) begin
			s_off += off_win[i];
			s_on += on_win[i];
		end
		oa = (s_off + win_fill / 2) / win_fill;
		na = (s_on + win_fill / 2) / win_fill;
		raw = na - oa;
		raw16 = raw * 256;
		absd = raw < 0 ? -raw : raw;
		ok = (na >= r_min_on) || (absd >= r_min_delta);
		// calibration mean
		if (streak >= r_warm && calib_n < r_calib) begin
			if (calib_n == 0) baseline_q16 = raw16;
			else baseline_q16 = fdiv(2 * (baseline_q16 * calib_n + raw16) + (calib_n + 1),
				2 * (calib_n + 1));
			calib_n++;
		end
		// slow downward adaptation
		if (calib_n >= r_calib && raw16 <= baseline_q16) begin
			d = baseline_q16 - raw16;
			baseline_q16 -= longint'((d * dsdt_pkg::ADAPT_Q16 + 32768) >> 16);
		end
		target = raw16 - baseline_q16;
		if (target < 0) target = 0;
		if (target > 64'hFFFFFFF) target = 64'hFFFFFFF;
		// rise clamp or decay
		if (target > smooth_q16) begin
			rise = target - smooth_q16;
			if (rise > longint'(r_rise) * 256) rise = longint'(r_rise) * 256;
			smooth_q16 += rise;
		end else begin
			d = smooth_q16 - target;
			smooth_q16 = target + longint'((d * r_decay + 32768) >> 16);
		end
		if (smooth_q16 < dsdt_pkg::FLOOR_Q16) smooth_q16 = 0;
		if (r_fs == 0) begin
			pct = 0; pm = 0;
		end else begin
			den = longint'(r_fs) * 256;
			acc = smooth_q16;
			if (acc >= den) begin
				pct = 100; pm = r_fs_pm * 10;
			end else begin
				pct = 32'((acc * 200 + den) / (2 * den));
				pm = 32'((acc * 20 * r_fs_pm + den) / (2 * den));
			end
		end
		cls = pct < 10 ? 0 : pct < 35 ? 1 : pct < 65 ? 2 : pct < 90 ? 3 : 4;
		if (!ok) begin
			streak = 0; st = dsdt_pkg::ST_NO_SIGNAL;
		end else begin
			if (streak < 255) streak++;
			if (streak < r_warm) st = dsdt_pkg::ST_WARMUP;
			else if (calib_n < r_calib) st = dsdt_pkg::ST_CALIB;
			else st = dsdt_pkg::ST_READY;
		end
		r.off_avg = 20'(oa); r.on_avg = 20'(na); r.raw_delta = 21'(raw);
		r.baseline = 21'(fdiv(baseline_q16, 256));
		r.smoothed = 20'(smooth_q16 >> 8);
		r.pct = 7'(pct); r.cls = 3'(cls); r.pm = 14'(pm); r.status = 2'(st);
		r.rdy = (st == dsdt_pkg::ST_READY);
		return r;
	endfunction

	// receiver with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (!arst_n || rx_hold) out_ready <= 1'b0;
		else out_ready <= !(idle_on && $urandom_range(99) < 8);
	end

	// result monitor
	always @(posedge clk) begin
		tracker_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transaction");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (off_avg !== e.off_avg) begin
					$error("off_avg exp %0d got %0d", e.off_avg, off_avg); errors++; end
				if (on_avg !== e.on_avg) begin
					$error("on_avg exp %0d got %0d", e.on_avg, on_avg); errors++; end
				if (raw_delta !== e.raw_delta) begin
					$error("raw_delta exp %0d got %0d", $signed(e.raw_delta), raw_delta);
					errors++;
				end
				if (baseline_out !== e.baseline) begin
					$error("baseline_out exp %0d got %0d", $signed(e.baseline), baseline_out);
					errors++;
				end
				if (smoothed_out !== e.smoothed) begin
					$error("smoothed_out exp %0d got %0d", e.smoothed, smoothed_out); errors++; end
				if (level_pct !== e.pct) begin
					$error("level_pct exp %0d got %0d", e.pct, level_pct); errors++; end
				if (level_class !== e.cls) begin
					$error("level_class exp %0d got %0d", e.cls, level_class); errors++; end
				if (pm_tenths !== e.pm) begin
					$error("pm_tenths exp %0d got %0d", e.pm, pm_tenths); errors++; end
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status); errors++; end
				if (ready_res !== e.rdy) begin
					$error("ready_res exp %0d got %0d", e.rdy, ready_res); errors++; end
			end
		end
	end

	// send one measurement transaction
	task automatic send_measurement(logic [19:0] offv, logic [19:0] onv);
		while (idle_on && $urandom_range(99) < 8) @(posedge clk);
		in_valid <= 1'b1;
		off_level <= offv;
		on_level <= onv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(track_measurement(offv, onv));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(dsdt_pkg::cfg_idx_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 20'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dsdt_pkg::CFG_WARMUP:    r_warm = val & 4'hF;
			dsdt_pkg::CFG_CALIB:     r_calib = val & 4'hF;
			dsdt_pkg::CFG_MIN_ON:    r_min_on = val & 20'hFFFFF;
			dsdt_pkg::CFG_MIN_DELTA: r_min_delta = val & 20'hFFFFF;
			dsdt_pkg::CFG_MAX_RISE:  r_rise = val & 16'hFFFF;
			dsdt_pkg::CFG_DECAY:     r_decay = val & 16'hFFFF;
			dsdt_pkg::CFG_FS_LEVEL:  r_fs = val & 20'hFFFFF;
			dsdt_pkg::CFG_FS_PM:     r_fs_pm = val & 10'h3FF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [19:0] rand_level();
		case ($urandom_range(3))
			0: return 20'($urandom_range(1048575));
			1: return 20'($urandom_range(4095));
			2: return 20'($urandom_range(1048575, 1040000));
			default: return 20'd3000 + 20'($urandom_range(2000));
		endcase
	endfunction

	// directed extremes, no signal, zero full scale and zero counts
	task automatic test_directed();
		send_measurement(20'd0, 20'd0);
		send_measurement(20'hFFFFF, 20'hFFFFF);
		send_measurement(20'hFFFFF, 20'd0);
		send_measurement(20'd0, 20'hFFFFF);
		repeat (6) send_measurement(20'd1000, 20'd1300);
		repeat (4) send_measurement(20'd1000, 20'd3000);
		repeat (3) send_measurement(20'd1000, 20'd800);
		wait_drained();
		write_reg(dsdt_pkg::CFG_WARMUP, 0);
		write_reg(dsdt_pkg::CFG_CALIB, 0);
		write_reg(dsdt_pkg::CFG_FS_LEVEL, 0);
		write_reg(dsdt_pkg::CFG_MIN_ON, 0);
		repeat (5) send_measurement(20'd500, 20'hFFFFF);
		wait_drained();
	endtask

	// random measurements over a register setting
	task automatic test_random_phase(int n, int unsigned warm, int unsigned cal,
		int unsigned mon, int unsigned mdl, int unsigned rise, int unsigned dec,
		int unsigned fs, int unsigned fsp);
		logic [19:0] base_off, base_on;
		write_reg(dsdt_pkg::CFG_WARMUP, warm);
		write_reg(dsdt_pkg::CFG_CALIB, cal);
		write_reg(dsdt_pkg::CFG_MIN_ON, mon);
		write_reg(dsdt_pkg::CFG_MIN_DELTA, mdl);
		write_reg(dsdt_pkg::CFG_MAX_RISE, rise);
		write_reg(dsdt_pkg::CFG_DECAY, dec);
		write_reg(dsdt_pkg::CFG_FS_LEVEL, fs);
		write_reg(dsdt_pkg::CFG_FS_PM, fsp);
		base_off = 20'($urandom_range(2000));
		base_on = base_off + 20'($urandom_range(3000));
		for (int i = 0; i < n; i++) begin
			// mostly a jittering clean-air signal with dust bursts, some noise
			if ($urandom_range(9) < 8)
				send_measurement(base_off + 20'($urandom_range(64)),
					base_on + 20'($urandom_range(4) == 0 ? $urandom_range(6000) :
					$urandom_range(64)));
			else
				send_measurement(rand_level(), rand_level());
		end
		wait_drained();
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (1500) @(posedge clk);
				rx_hold = 1'b0;
			end
			for (int i = 0; i < 30; i++) send_measurement(rand_level(), rand_level());
		join
		wait_drained();
	endtask

	initial begin
		defaults_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(150, 3, 8, 512, 256, 77, 58982, 2048, 500);
		test_random_phase(150, 15, 15, 1048320, 1048320, 1, 0, 1, 1);
		test_random_phase(150, 1, 1, 0, 0, 65535, 65535, 1048320, 1000);
		idle_on = 1'b0;
		test_random_phase(150, 0, 0, 3000, 500, 300, 40000, 4000, 250);
		idle_on = 1'b1;
		test_backpressure();
		test_random_phase(150, 2, 4, 2000, 100, 20, 60000, 1, 1000);
		// lowered calibration count keeps progress
		test_random_phase(150, 1, 2, 800, 300, 500, 30000, 3000, 700);
		if (errors == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/dsdt_pkg.sv
rtl/dsdt_div.sv
rtl/dsdt_ctrl.sv
rtl/dsdt_dp.sv
rtl/dust_sensor_delta_tracker.sv
tb/tb.sv
